>>> rtl/core/prx_pkg.sv
// ----------------------------------------------------------------------------
// prx_pkg
// Shared types, codes, reset values and the byte-wide CRC-16 step of the
// preamble-synchronised frame receiver.
// ----------------------------------------------------------------------------
package prx_pkg;

  localparam int PREAMBLE_COUNT_DEF = 8;
  localparam int QUEUE_DEPTH_DEF    = 4;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_BAD_CRC = 2'd2;
  localparam logic [1:0] KIND_BAD_LEN = 2'd3;

  localparam logic [1:0] REG_CRC_POLY  = 2'd0;
  localparam logic [1:0] REG_CRC_START = 2'd1;
  localparam logic [1:0] REG_PREAMBLE  = 2'd2;
  localparam logic [1:0] REG_TRAILER   = 2'd3;

  localparam logic [15:0] CRC_POLY_RST  = 16'h1021;
  localparam logic [15:0] CRC_START_RST = 16'hFFFF;
  localparam logic [7:0]  PREAMBLE_RST  = 8'hA5;
  localparam logic [7:0]  TRAILER_RST   = 8'd8;

  typedef struct packed {
    logic [15:0] crc_poly;
    logic [15:0] crc_start;
    logic [7:0]  preamble;
    logic [7:0]  trailer;
  } cfg_t;

  // Classified transaction handed from front to back.
  // KIND_GOOD here marks the CRC check; the back decides good or bad.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [6:0]  index;
    logic [7:0]  flen;
    logic [15:0] rcrc;
  } token_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data,
                                           input logic [15:0] poly);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/core/prx_in_if.sv
// ----------------------------------------------------------------------------
// prx_in_if
// Received byte channel: valid/ready handshake with one byte of payload.
// ----------------------------------------------------------------------------
interface prx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

>>> rtl/core/prx_out_if.sv
// ----------------------------------------------------------------------------
// prx_out_if
// Result channel: valid/ready handshake with one result record.
// ----------------------------------------------------------------------------
interface prx_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic [6:0]  out_index;
  logic        out_last;
  logic [7:0]  out_len;
  logic [15:0] received_crc;
  logic [15:0] computed_crc;

  modport source (output valid, output out_kind, output out_byte, output out_index,
                  output out_last, output out_len, output received_crc,
                  output computed_crc, input ready);
  modport sink   (input valid, input out_kind, input out_byte, input out_index,
                  input out_last, input out_len, input received_crc,
                  input computed_crc, output ready);
endinterface

>>> rtl/core/prx_front.sv
// ----------------------------------------------------------------------------
// prx_front
// Frame state machine: preamble hunt, length check, payload indexing, CRC
// byte capture and trailer skip. Pushes classified transactions to the queue.
// ----------------------------------------------------------------------------
module prx_front #(
  parameter int PREAMBLE_COUNT = prx_pkg::PREAMBLE_COUNT_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  prx_in_if.sink          in_chan,
  input  prx_pkg::cfg_t   cfg,
  input  logic            q_ready,
  output logic            push,
  output prx_pkg::token_t push_tok
);

  localparam int RUN_W = $clog2(PREAMBLE_COUNT + 1);

  localparam logic [2:0] M_HUNT  = 3'd0;
  localparam logic [2:0] M_LEN   = 3'd1;
  localparam logic [2:0] M_PAY   = 3'd2;
  localparam logic [2:0] M_CRCH  = 3'd3;
  localparam logic [2:0] M_CRCL  = 3'd4;
  localparam logic [2:0] M_TRAIL = 3'd5;

  logic [2:0]       mode_r, mode_nxt;
  logic [RUN_W-1:0] run_r, run_nxt, run_inc;
  logic [7:0]       len_r, len_nxt;
  logic [6:0]       pos_r, pos_nxt, pos_inc;
  logic [7:0]       crch_r, crch_nxt;
  logic [7:0]       skip_r, skip_nxt, skip_dec;
  logic [7:0]       b;
  logic             acc;

  assign in_chan.ready = q_ready;
  assign acc           = in_chan.valid && q_ready;
  assign b             = in_chan.in_byte;
  assign run_inc       = run_r + 1'b1;
  assign pos_inc       = pos_r + 1'b1;
  assign skip_dec      = skip_r - 1'b1;

  always_comb begin
    mode_nxt = mode_r;
    run_nxt  = run_r;
    len_nxt  = len_r;
    pos_nxt  = pos_r;
    crch_nxt = crch_r;
    skip_nxt = skip_r;
    push     = 1'b0;
    push_tok = '0;
    if (acc) begin
      case (mode_r)
        M_LEN: begin
          len_nxt = b;
          if (b == 8'd0 || b[7]) begin
            mode_nxt       = M_HUNT;
            run_nxt        = '0;
            push           = 1'b1;
            push_tok.kind  = prx_pkg::KIND_BAD_LEN;
            push_tok.flen  = b;
          end else begin
            pos_nxt  = '0;
            mode_nxt = M_PAY;
          end
        end
        M_PAY: begin
          push           = 1'b1;
          push_tok.kind  = prx_pkg::KIND_PAYLOAD;
          push_tok.data  = b;
          push_tok.index = pos_r;
          push_tok.flen  = len_r;
          pos_nxt        = pos_inc;
          if ({1'b0, pos_inc} >= len_r) begin
            mode_nxt = M_CRCH;
          end
        end
        M_CRCH: begin
          crch_nxt = b;
          mode_nxt = M_CRCL;
        end
        M_CRCL: begin
          push          = 1'b1;
          push_tok.kind = prx_pkg::KIND_GOOD;
          push_tok.flen = len_r;
          push_tok.rcrc = {crch_r, b};
          skip_nxt      = cfg.trailer;
          run_nxt       = '0;
          mode_nxt      = (cfg.trailer != 8'd0) ? M_TRAIL : M_HUNT;
        end
        M_TRAIL: begin
          skip_nxt = skip_dec;
          if (skip_dec == 8'd0) begin
            mode_nxt = M_HUNT;
            run_nxt  = '0;
          end
        end
        default: begin
          mode_nxt = M_HUNT;
          if (b == cfg.preamble) begin
            run_nxt = run_inc;
            if (run_inc == RUN_W'(PREAMBLE_COUNT)) begin
              run_nxt  = '0;
              mode_nxt = M_LEN;
            end
          end else begin
            run_nxt = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_HUNT;
      run_r  <= '0;
      len_r  <= '0;
      pos_r  <= '0;
      crch_r <= '0;
      skip_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      run_r  <= run_nxt;
      len_r  <= len_nxt;
      pos_r  <= pos_nxt;
      crch_r <= crch_nxt;
      skip_r <= skip_nxt;
    end
  end

endmodule

>>> rtl/core/prx_queue.sv
// ----------------------------------------------------------------------------
// prx_queue
// Short register FIFO of classified transactions between front and back.
// ----------------------------------------------------------------------------
module prx_queue #(
  parameter int DEPTH = prx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  prx_pkg::token_t push_tok,
  output logic            push_ready,
  output logic            pop_valid,
  output prx_pkg::token_t pop_tok,
  input  logic            pop
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  prx_pkg::token_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = cnt_r != CNT_W'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_tok    = mem_r[rd_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/core/prx_back.sv
// ----------------------------------------------------------------------------
// prx_back
// Runs the CRC over payload transactions, checks the received CRC and holds
// each result in the output register until the sink takes it.
// ----------------------------------------------------------------------------
module prx_back (
  input  logic            clk,
  input  logic            rst_n,
  input  prx_pkg::cfg_t   cfg,
  input  logic            q_valid,
  input  prx_pkg::token_t q_tok,
  output logic            q_pop,
  prx_out_if.source       out_chan
);

  logic        ov_r, ov_nxt;
  logic [15:0] crc_r, crc_nxt, crc_base;
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  data_r, data_nxt;
  logic [6:0]  idx_r, idx_nxt;
  logic        last_r, last_nxt;
  logic [7:0]  flen_r, flen_nxt;
  logic [15:0] rcrc_r, rcrc_nxt;
  logic [15:0] ccrc_r, ccrc_nxt;

  assign q_pop    = q_valid && (!ov_r || out_chan.ready);
  assign crc_base = (q_tok.index == 7'd0) ? cfg.crc_start : crc_r;

  always_comb begin
    ov_nxt   = ov_r && !out_chan.ready;
    crc_nxt  = crc_r;
    kind_nxt = kind_r;
    data_nxt = data_r;
    idx_nxt  = idx_r;
    last_nxt = last_r;
    flen_nxt = flen_r;
    rcrc_nxt = rcrc_r;
    ccrc_nxt = ccrc_r;
    if (q_pop) begin
      ov_nxt   = 1'b1;
      data_nxt = '0;
      idx_nxt  = '0;
      last_nxt = 1'b1;
      flen_nxt = q_tok.flen;
      rcrc_nxt = '0;
      ccrc_nxt = '0;
      case (q_tok.kind)
        prx_pkg::KIND_PAYLOAD: begin
          crc_nxt  = prx_pkg::crc_byte(crc_base, q_tok.data, cfg.crc_poly);
          kind_nxt = prx_pkg::KIND_PAYLOAD;
          data_nxt = q_tok.data;
          idx_nxt  = q_tok.index;
          last_nxt = 1'b0;
        end
        prx_pkg::KIND_GOOD: begin
          kind_nxt = (q_tok.rcrc == crc_r) ? prx_pkg::KIND_GOOD : prx_pkg::KIND_BAD_CRC;
          rcrc_nxt = q_tok.rcrc;
          ccrc_nxt = crc_r;
        end
        default: begin
          kind_nxt = prx_pkg::KIND_BAD_LEN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      crc_r <= prx_pkg::CRC_START_RST;
    end else begin
      ov_r  <= ov_nxt;
      crc_r <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    data_r <= data_nxt;
    idx_r  <= idx_nxt;
    last_r <= last_nxt;
    flen_r <= flen_nxt;
    rcrc_r <= rcrc_nxt;
    ccrc_r <= ccrc_nxt;
  end

  assign out_chan.valid        = ov_r;
  assign out_chan.out_kind     = kind_r;
  assign out_chan.out_byte     = data_r;
  assign out_chan.out_index    = idx_r;
  assign out_chan.out_last     = last_r;
  assign out_chan.out_len      = flen_r;
  assign out_chan.received_crc = rcrc_r;
  assign out_chan.computed_crc = ccrc_r;

endmodule

>>> rtl/core/preamble_sync_frame_crc_receiver.sv
// ----------------------------------------------------------------------------
// preamble_sync_frame_crc_receiver
// Preamble-synchronised frame receiver with length check and CRC-16 check.
//
// in_chan takes one received byte per transaction; out_chan gives one result
// per payload byte and one status (good, CRC mismatch, bad length) that closes
// each frame. Preamble, good length, first CRC and trailer bytes give no
// result. A byte is taken every cycle while the queue has room; a result
// passes from the front state machine into the queue, then through the CRC
// step into the output register, before out_chan.valid rises. Sustained rate
// is one byte per cycle while the sink takes every result, set by the
// byte-wide CRC step in the back end. When the sink stalls, results wait in
// the output register and the queue fills; in_chan.ready drops only once the
// queue is full.
// Reset (rst_n low, synchronous) returns to preamble hunt, empties the queue
// and loads the register defaults. The APB port sits at word addresses:
// polynomial, CRC start, preamble value, trailer count.
// ----------------------------------------------------------------------------
module preamble_sync_frame_crc_receiver #(
  parameter int PREAMBLE_COUNT = prx_pkg::PREAMBLE_COUNT_DEF,
  parameter int QUEUE_DEPTH    = prx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  prx_in_if.sink      in_chan,
  prx_out_if.source   out_chan,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  prx_pkg::cfg_t   cfg_r, cfg_nxt;
  prx_pkg::token_t push_tok, q_tok;
  logic            push, q_ready, q_valid, q_pop, wr_en;
  logic [1:0]      reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        prx_pkg::REG_CRC_POLY:  cfg_nxt.crc_poly  = cfg_pwdata[15:0];
        prx_pkg::REG_CRC_START: cfg_nxt.crc_start = cfg_pwdata[15:0];
        prx_pkg::REG_PREAMBLE:  cfg_nxt.preamble  = cfg_pwdata[7:0];
        prx_pkg::REG_TRAILER:   cfg_nxt.trailer   = cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      prx_pkg::REG_CRC_POLY:  cfg_prdata = {16'h0000, cfg_r.crc_poly};
      prx_pkg::REG_CRC_START: cfg_prdata = {16'h0000, cfg_r.crc_start};
      prx_pkg::REG_PREAMBLE:  cfg_prdata = {24'h000000, cfg_r.preamble};
      prx_pkg::REG_TRAILER:   cfg_prdata = {24'h000000, cfg_r.trailer};
      default:                cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.crc_poly  <= prx_pkg::CRC_POLY_RST;
      cfg_r.crc_start <= prx_pkg::CRC_START_RST;
      cfg_r.preamble  <= prx_pkg::PREAMBLE_RST;
      cfg_r.trailer   <= prx_pkg::TRAILER_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  prx_front #(
    .PREAMBLE_COUNT (PREAMBLE_COUNT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg      (cfg_r),
    .q_ready  (q_ready),
    .push     (push),
    .push_tok (push_tok)
  );

  prx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_tok   (push_tok),
    .push_ready (q_ready),
    .pop_valid  (q_valid),
    .pop_tok    (q_tok),
    .pop        (q_pop)
  );

  prx_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (q_valid),
    .q_tok    (q_tok),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule
